FILE: hw/rtl/mwoc_pkg.sv
// ----------------------------------------------------------------------------
// mwoc_pkg
// Shared types and constants for the microwave oven controller.
// ----------------------------------------------------------------------------
package mwoc_pkg;

   // Default number of 100 ms ticks that make one cooking second
   localparam int unsigned TICKS_PER_SECOND_DEF = 10;

   localparam int unsigned KIND_W   = 2;
   localparam int unsigned SECS_W   = 8;
   localparam int unsigned TICK_W   = 4;
   localparam int unsigned MODE_W   = 2;

   typedef enum logic [KIND_W-1:0] {
      EV_TICK   = 2'd0,
      EV_DOOR   = 2'd1,
      EV_BUTTON = 2'd2,
      EV_SELECT = 2'd3
   } event_kind_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_OFF   = 2'd0,
      MODE_RUN   = 2'd1,
      MODE_PAUSE = 2'd2
   } oven_mode_type;

   // One input event
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              door_closed;
      logic [SECS_W-1:0] time_value;
   } event_type;

   // One result item
   typedef struct packed {
      logic              magnetron_on;
      logic              inner_light_on;
      logic              cook_light_on;
      logic [MODE_W-1:0] oven_mode;
      logic [SECS_W-1:0] seconds_left;
      logic              refresh;
   } result_type;

endpackage

FILE: hw/rtl/mwoc_if.sv
// ----------------------------------------------------------------------------
// mwoc_if
// Valid/ready channels for oven events and oven results.
// ----------------------------------------------------------------------------
interface mwoc_req_if
   import mwoc_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic              door_closed;
   logic [SECS_W-1:0] time_value;

   modport source (output valid, output kind, output door_closed, output time_value,
                   input ready);
   modport sink   (input valid, input kind, input door_closed, input time_value,
                   output ready);
endinterface

interface mwoc_rsp_if
   import mwoc_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              magnetron_on;
   logic              inner_light_on;
   logic              cook_light_on;
   logic [MODE_W-1:0] oven_mode;
   logic [SECS_W-1:0] seconds_left;
   logic              refresh;

   modport source (output valid, output magnetron_on, output inner_light_on,
                   output cook_light_on, output oven_mode, output seconds_left,
                   output refresh, input ready);
   modport sink   (input valid, input magnetron_on, input inner_light_on,
                   input cook_light_on, input oven_mode, input seconds_left,
                   input refresh, output ready);
endinterface

FILE: hw/rtl/microwave_oven_controller_unit.sv
// ----------------------------------------------------------------------------
// microwave_oven_controller_unit
// Cooking-timer controller: one result transfer for every event transfer.
// ----------------------------------------------------------------------------
//
//   channel | direction | carries
//   --------+-----------+----------------------------------------------------
//   req_ch  | in        | kind, door_closed, time_value (one event)
//   rsp_ch  | out       | lights, heater, mode, seconds left, refresh flag
//
//   One event a cycle while the result is not stalled: the update is a
//   single combinational pass from the event and the state registers into
//   the result register, which is valid in the cycle after the transfer.
//   Reset (synchronous) puts the oven off, door open, all counts zero.
//   A stalled result holds in the result register; a new event is still
//   taken in the cycle the held result is transferred out.
//
module microwave_oven_controller_unit
   import mwoc_pkg::*;
#(
   parameter int unsigned TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
) (
   input  logic        clock,
   input  logic        reset,
   mwoc_req_if.sink    req_ch,
   mwoc_rsp_if.source  rsp_ch
);

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;
   result_type next_result;
   event_type  evt;
   logic       evt_accept;

   // Take an event whenever the result register is empty or drains this cycle
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign evt_accept   = req_ch.valid && req_ch.ready;

   assign evt = '{
      kind:        req_ch.kind,
      door_closed: req_ch.door_closed,
      time_value:  req_ch.time_value
   };

   mwoc_core #(
      .TICKS_PER_SECOND (TICKS_PER_SECOND)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .evt_accept (evt_accept),
      .evt        (evt),
      .result     (next_result)
   );

   // Hold the result until the sink takes it; refill on each event transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (evt_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      if (evt_accept) begin
         rsp_data_ff <= next_result;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.magnetron_on   = rsp_data_ff.magnetron_on;
   assign rsp_ch.inner_light_on = rsp_data_ff.inner_light_on;
   assign rsp_ch.cook_light_on  = rsp_data_ff.cook_light_on;
   assign rsp_ch.oven_mode      = rsp_data_ff.oven_mode;
   assign rsp_ch.seconds_left   = rsp_data_ff.seconds_left;
   assign rsp_ch.refresh        = rsp_data_ff.refresh;

endmodule

FILE: hw/rtl/mwoc_core.sv
// ----------------------------------------------------------------------------
// mwoc_core
// Oven state registers and the single-pass update for one event.
// ----------------------------------------------------------------------------
module mwoc_core
   import mwoc_pkg::*;
#(
   parameter int unsigned TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       evt_accept,
   input  event_type  evt,
   output result_type result
);

   localparam logic [TICK_W-1:0] TICK_LAST = TICK_W'(TICKS_PER_SECOND);

   oven_mode_type     mode_ff, mode_in;
   logic              door_ff, door_in;
   logic [SECS_W-1:0] remaining_ff, remaining_in;
   logic [SECS_W-1:0] selection_ff, selection_in;
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic              heater_ff, heater_in;
   logic              lamp_ff, lamp_in;
   logic              blink_ff, blink_in;
   logic              refresh;

   logic [TICK_W-1:0] tick_inc;
   logic              second_done;
   logic              run_end;
   logic              button_stop;
   logic              button_start;

   assign tick_inc     = tick_ff + TICK_W'(1);
   assign second_done  = (mode_ff == MODE_RUN) && (tick_inc >= TICK_LAST);
   assign run_end      = (evt.kind == EV_TICK) && second_done && (remaining_ff == '0);
   assign button_stop  = (evt.kind == EV_BUTTON) &&
                         ((door_ff && mode_ff == MODE_RUN) ||
                          (!door_ff && mode_ff != MODE_OFF));
   assign button_start = (evt.kind == EV_BUTTON) && door_ff && (mode_ff != MODE_RUN);

   // Next mode
   always_comb begin
      mode_in = mode_ff;
      if (run_end || button_stop) begin
         mode_in = MODE_OFF;
      end else if (button_start) begin
         mode_in = MODE_RUN;
      end else if (evt.kind == EV_DOOR && mode_ff == MODE_RUN && !evt.door_closed) begin
         mode_in = MODE_PAUSE;
      end
   end

   // Datapath and lights
   always_comb begin
      door_in      = door_ff;
      remaining_in = remaining_ff;
      selection_in = selection_ff;
      tick_in      = tick_ff;
      heater_in    = heater_ff;
      lamp_in      = lamp_ff;
      blink_in     = blink_ff;
      refresh      = 1'b1;
      case (evt.kind)
         EV_TICK: begin
            refresh = 1'b0;
            if (mode_ff == MODE_PAUSE || mode_ff == MODE_RUN) begin
               blink_in = ~blink_ff;
            end
            if (mode_ff == MODE_RUN) begin
               tick_in = tick_inc;
               if (second_done) begin
                  tick_in = '0;
                  refresh = 1'b1;
                  if (remaining_ff != '0) begin
                     remaining_in = remaining_ff - SECS_W'(1);
                  end else begin
                     heater_in = 1'b0;
                     lamp_in   = 1'b0;
                     blink_in  = 1'b0;
                  end
               end
            end
         end
         EV_DOOR: begin
            door_in = evt.door_closed;
            if (mode_ff == MODE_RUN && !evt.door_closed) begin
               heater_in = 1'b0;
            end
            lamp_in = !evt.door_closed || (mode_in == MODE_RUN);
         end
         EV_BUTTON: begin
            if (button_stop) begin
               remaining_in = '0;
               heater_in    = 1'b0;
               lamp_in      = 1'b0;
               blink_in     = 1'b0;
            end else if (button_start) begin
               if (remaining_ff == '0) begin
                  remaining_in = selection_ff;
               end
               heater_in = 1'b1;
               lamp_in   = 1'b1;
            end
         end
         default: begin
            selection_in = evt.time_value;
         end
      endcase
   end

   // Result reflects the state after the event
   assign result = '{
      magnetron_on:   heater_in,
      inner_light_on: lamp_in,
      cook_light_on:  blink_in,
      oven_mode:      mode_in,
      seconds_left:   remaining_in,
      refresh:        refresh
   };

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_OFF;
         door_ff      <= 1'b0;
         remaining_ff <= '0;
         selection_ff <= '0;
         tick_ff      <= '0;
         heater_ff    <= 1'b0;
         lamp_ff      <= 1'b0;
         blink_ff     <= 1'b0;
      end else if (evt_accept) begin
         mode_ff      <= mode_in;
         door_ff      <= door_in;
         remaining_ff <= remaining_in;
         selection_ff <= selection_in;
         tick_ff      <= tick_in;
         heater_ff    <= heater_in;
         lamp_ff      <= lamp_in;
         blink_ff     <= blink_in;
      end
   end

   a_heater_only_running: assert property (@(posedge clock) disable iff (reset)
      heater_ff |-> mode_ff == MODE_RUN)
      else $error("heater on outside a run");

   a_off_is_clear: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_OFF |-> (remaining_ff == '0 && !blink_ff))
      else $error("oven off with time or blink left");

   a_tick_in_range: assert property (@(posedge clock) disable iff (reset)
      tick_ff < TICK_LAST)
      else $error("tick count reached a full second");

   a_select_keeps_mode: assert property (@(posedge clock) disable iff (reset)
      evt_accept && evt.kind == EV_SELECT |=> $stable(mode_ff) && $stable(remaining_ff))
      else $error("time selection disturbed the run");

endmodule
